// ===== design/nwi_pkg.sv =====
package nwi_pkg;

  // Q32.32 limits
  localparam logic [63:0] Q_MIN = 64'h8000_0000_0000_0000;
  localparam logic [63:0] Q_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] Q_TOP = 64'h8000_0000_0000_0000;
  localparam logic [63:0] Q_ONE = 64'h0000_0001_0000_0000;

  // Input kinds on tuser
  localparam logic MODE_LOAD  = 1'b0;
  localparam logic MODE_QUERY = 1'b1;

  // Result status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NOT_READY = 2'd1;
  localparam logic [1:0] ST_DIV_ERR   = 2'd2;
  localparam logic [1:0] ST_SAT       = 2'd3;

  // Serial divider: 80 quotient bits (64-bit magnitude shifted up by 16)
  localparam int DIV_STEPS = 80;
  localparam int DIV_CW    = 7;

  typedef struct packed {
    logic        sat;
    logic [63:0] val;
  } sat_val_t;

  typedef enum logic [1:0] {
    WSEL_LOAD,
    WSEL_ZERO,
    WSEL_DIV
  } wsel_t;

  typedef enum logic [1:0] {
    OK_CALC,
    OK_NOT_READY,
    OK_DIV_ERR
  } okind_t;

  // Controller to datapath commands
  typedef struct packed {
    logic   wr_x;
    logic   wr_c;
    wsel_t  wsel;
    logic   clr_bsat;
    logic   cap_a;
    logic   cap_b;
    logic   div_start;
    logic   note_num_sat;
    logic   note_div_sat;
    logic   q_init;
    logic   cap_res;
    logic   mul_start;
    logic   mul_sel;
    logic   upd_prod;
    logic   acc_term;
    logic   out_load;
    okind_t okind;
  } nwi_cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic den_zero;
    logic div_done;
    logic mul_done;
  } nwi_stat_t;

  function automatic logic [63:0] mag64(logic [63:0] v);
    logic [63:0] m;
    m = v[63] ? (~v + 64'd1) : v;
    return m;
  endfunction

  // Apply sign to a magnitude, saturating to the signed 64-bit range
  function automatic sat_val_t from_mag(logic [63:0] mag, logic neg, logic ovf);
    sat_val_t r;
    r.sat = 1'b0;
    if (neg) begin
      if (ovf || mag > Q_TOP) begin
        r.sat = 1'b1;
        r.val = Q_MIN;
      end else begin
        r.val = ~mag + 64'd1;
      end
    end else begin
      if (ovf || mag >= Q_TOP) begin
        r.sat = 1'b1;
        r.val = Q_MAX;
      end else begin
        r.val = mag;
      end
    end
    return r;
  endfunction

  function automatic sat_val_t sat_add(logic [63:0] a, logic [63:0] b);
    sat_val_t    r;
    logic [63:0] s;
    s     = a + b;
    r.sat = 1'b0;
    r.val = s;
    if (a[63] == b[63] && s[63] != a[63]) begin
      r.sat = 1'b1;
      r.val = a[63] ? Q_MIN : Q_MAX;
    end
    return r;
  endfunction

endpackage

// ===== design/nwi_mul.sv =====
module nwi_mul (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [63:0]       a,
  input  logic [63:0]       b,
  input  logic              sel32,
  output logic              done,
  output nwi_pkg::sat_val_t res
);
  import nwi_pkg::*;

  logic [63:0]  am;
  logic [63:0]  bm;
  logic         neg;
  logic         shr32;
  logic         busy;
  logic [2:0]   cnt;
  logic [63:0]  p;
  logic [1:0]   poff;
  logic         pv;
  logic [127:0] acc;
  logic [31:0]  ah;
  logic [31:0]  bh;
  logic [63:0]  pp;
  logic [127:0] addend;
  logic [127:0] shifted;

  // Pick the halves for this partial product
  assign ah = cnt[0] ? am[63:32] : am[31:0];
  assign bh = cnt[1] ? bm[63:32] : bm[31:0];
  assign pp = ah * bh;

  always_comb begin
    case (poff)
      2'd0:    addend = {64'd0, p};
      2'd1:    addend = {32'd0, p, 32'd0};
      2'd2:    addend = {p, 64'd0};
      default: addend = '0;
    endcase
  end

  assign shifted = shr32 ? (acc >> 32) : (acc >> 16);

  // Four 32x32 partial products, one a cycle, each registered and added to the sum in the cycle after
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      pv   <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        am    <= mag64(a);
        bm    <= mag64(b);
        neg   <= a[63] ^ b[63];
        shr32 <= sel32;
        acc   <= '0;
        cnt   <= '0;
        pv    <= 1'b0;
        busy  <= 1'b1;
      end else if (busy) begin
        if (cnt < 3'd4) begin
          p <= pp;
        end
        pv   <= (cnt < 3'd4);
        poff <= {1'b0, cnt[0]} + {1'b0, cnt[1]};
        if (pv) begin
          acc <= acc + addend;
        end
        cnt <= cnt + 3'd1;
        if (cnt == 3'd5) begin
          res  <= from_mag(shifted[63:0], neg, |shifted[127:64]);
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== design/nwi_div.sv =====
module nwi_div (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [63:0]       num,
  input  logic [32:0]       den,
  output logic              done,
  output nwi_pkg::sat_val_t res
);
  import nwi_pkg::*;

  logic [DIV_STEPS-1:0] dq;
  logic [32:0]          r;
  logic [32:0]          dm;
  logic                 neg;
  logic                 busy;
  logic [DIV_CW-1:0]    cnt;
  logic [33:0]          rs;
  logic                 qbit;
  logic [33:0]          rdiff;
  logic [DIV_STEPS-1:0] qfin;

  // One restoring step a cycle
  assign rs    = {r, dq[DIV_STEPS-1]};
  assign qbit  = (rs >= {1'b0, dm});
  assign rdiff = rs - {1'b0, dm};
  assign qfin  = {dq[DIV_STEPS-2:0], qbit};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        dq   <= {mag64(num), 16'd0};
        r    <= '0;
        dm   <= den[32] ? (~den + 33'd1) : den;
        neg  <= num[63] ^ den[32];
        cnt  <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        r   <= qbit ? rdiff[32:0] : rs[32:0];
        dq  <= qfin;
        cnt <= cnt + DIV_CW'(1);
        if (cnt == DIV_CW'(DIV_STEPS - 1)) begin
          res  <= from_mag(qfin[63:0], neg, |qfin[DIV_STEPS-1:64]);
          done <= 1'b1;
          busy <= 1'b0;
        end
      end
    end
  end

endmodule

// ===== design/nwi_datapath.sv =====
module nwi_datapath #(
  parameter int MAX_POINTS = 64,
  parameter int AW         = 6
) (
  input  logic               clk,
  input  logic               rst,
  input  nwi_pkg::nwi_cmd_t  cmd,
  input  logic [AW-1:0]      wr_addr,
  input  logic [AW-1:0]      rd_x_addr,
  input  logic [AW-1:0]      rd_c_addr,
  input  logic [31:0]        x_in,
  input  logic [31:0]        y_in,
  output nwi_pkg::nwi_stat_t stat,
  output logic [31:0]        y_result,
  output logic [1:0]         status
);
  import nwi_pkg::*;

  logic [31:0] x_mem [MAX_POINTS];
  logic [63:0] c_mem [MAX_POINTS];
  logic [31:0] x_rd;
  logic [63:0] c_rd;
  logic [31:0] xa;
  logic [31:0] xb;
  logic [63:0] ca;
  logic [63:0] cb;
  logic [31:0] qx;
  logic [63:0] prod;
  logic [63:0] res;
  logic        bsat;
  logic        qsat;
  logic [63:0] c_wdata;
  logic [32:0] den;
  logic [63:0] neg_cb;
  sat_val_t    numr;
  logic [32:0] qdiff;
  logic [63:0] mul_b;
  logic        mul_done;
  sat_val_t    mul_res;
  logic        div_done;
  sat_val_t    div_res;
  sat_val_t    acc_sum;
  logic [63:0] res_mag;
  logic [47:0] m48;
  logic [31:0] out_y;
  logic        conv_sat;

  // Build operands
  assign den    = {xa[31], xa} - {xb[31], xb};
  assign neg_cb = (cb == Q_MIN) ? Q_MAX : (~cb + 64'd1);
  assign numr   = sat_add(ca, neg_cb);

  // Query operands
  assign qdiff   = {qx[31], qx} - {xb[31], xb};
  assign mul_b   = cmd.mul_sel ? cb : {{31{qdiff[32]}}, qdiff};
  assign acc_sum = sat_add(res, mul_res.val);

  always_comb begin
    case (cmd.wsel)
      WSEL_LOAD: c_wdata = {{16{y_in[31]}}, y_in, 16'd0};
      WSEL_DIV:  c_wdata = div_res.val;
      default:   c_wdata = '0;
    endcase
  end

  // Q32.32 to Q16.16 with saturation
  always_comb begin
    res_mag  = mag64(res);
    m48      = res_mag[63:16];
    conv_sat = 1'b0;
    if (res[63]) begin
      if (m48 > 48'h0000_8000_0000) begin
        m48      = 48'h0000_8000_0000;
        conv_sat = 1'b1;
      end
      out_y = ~m48[31:0] + 32'd1;
    end else begin
      if (m48 > 48'h0000_7FFF_FFFF) begin
        m48      = 48'h0000_7FFF_FFFF;
        conv_sat = 1'b1;
      end
      out_y = m48[31:0];
    end
  end

  assign stat.den_zero = (den == 33'd0);
  assign stat.div_done = div_done;
  assign stat.mul_done = mul_done;

  // Sample and coefficient memories
  always_ff @(posedge clk) begin
    if (cmd.wr_x) begin
      x_mem[wr_addr] <= x_in;
    end
    if (cmd.wr_c) begin
      c_mem[wr_addr] <= c_wdata;
    end
    x_rd <= x_mem[rd_x_addr];
    c_rd <= c_mem[rd_c_addr];
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.cap_a) begin
      xa <= x_rd;
      ca <= c_rd;
    end
    if (cmd.cap_b) begin
      xb <= x_rd;
      cb <= c_rd;
    end
    if (cmd.q_init) begin
      qx   <= x_in;
      prod <= Q_ONE;
    end
    if (cmd.cap_res) begin
      res <= c_rd;
    end
    if (cmd.upd_prod) begin
      prod <= mul_res.val;
    end
    if (cmd.acc_term) begin
      res <= acc_sum.val;
    end
    if (cmd.out_load) begin
      case (cmd.okind)
        OK_NOT_READY: begin
          y_result <= '0;
          status   <= ST_NOT_READY;
        end
        OK_DIV_ERR: begin
          y_result <= '0;
          status   <= ST_DIV_ERR;
        end
        default: begin
          y_result <= out_y;
          status   <= (qsat || conv_sat) ? ST_SAT : ST_OK;
        end
      endcase
    end
  end

  // Saturation flags
  always_ff @(posedge clk) begin
    if (rst) begin
      bsat <= 1'b0;
      qsat <= 1'b0;
    end else begin
      if (cmd.clr_bsat) begin
        bsat <= 1'b0;
      end else if (cmd.note_num_sat || cmd.note_div_sat) begin
        bsat <= bsat | (cmd.note_num_sat & numr.sat) | (cmd.note_div_sat & div_res.sat);
      end
      if (cmd.q_init) begin
        qsat <= bsat;
      end else if (cmd.upd_prod) begin
        qsat <= qsat | mul_res.sat;
      end else if (cmd.acc_term) begin
        qsat <= qsat | mul_res.sat | acc_sum.sat;
      end
    end
  end

  nwi_mul u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.mul_start),
    .a     (prod),
    .b     (mul_b),
    .sel32 (cmd.mul_sel),
    .done  (mul_done),
    .res   (mul_res)
  );

  nwi_div u_div (
    .clk   (clk),
    .rst   (rst),
    .start (cmd.div_start),
    .num   (numr.val),
    .den   (den),
    .done  (div_done),
    .res   (div_res)
  );

endmodule

// ===== design/nwi_controller.sv =====
module nwi_controller #(
  parameter int MAX_POINTS = 64,
  parameter int AW         = 6,
  parameter int CW         = 7
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic               mode,
  output logic               m_tvalid,
  input  logic               m_tready,
  input  logic               cfg_we,
  input  logic [6:0]         cfg_data,
  input  nwi_pkg::nwi_stat_t stat,
  output nwi_pkg::nwi_cmd_t  cmd,
  output logic [AW-1:0]      wr_addr,
  output logic [AW-1:0]      rd_x_addr,
  output logic [AW-1:0]      rd_c_addr
);
  import nwi_pkg::*;

  localparam int CMPW = (CW > 7) ? CW : 7;

  typedef enum logic [14:0] {
    S_IDLE   = 15'b000000000000001,
    S_B_RD1  = 15'b000000000000010,
    S_B_RD2  = 15'b000000000000100,
    S_B_CAP  = 15'b000000000001000,
    S_B_DIV  = 15'b000000000010000,
    S_B_WAIT = 15'b000000000100000,
    S_Q_INIT = 15'b000000001000000,
    S_Q_RES  = 15'b000000010000000,
    S_Q_RD   = 15'b000000100000000,
    S_Q_CAP  = 15'b000001000000000,
    S_Q_MUL1 = 15'b000010000000000,
    S_Q_W1   = 15'b000100000000000,
    S_Q_MUL2 = 15'b001000000000000,
    S_Q_W2   = 15'b010000000000000,
    S_Q_FIN  = 15'b100000000000000
  } state_t;

  state_t      state;
  state_t      state_next;
  logic [6:0]  point_count;
  logic [CW-1:0] loaded;
  logic [CW-1:0] loaded_next;
  logic        table_ready;
  logic        table_ready_next;
  logic        derr;
  logic        derr_next;
  logic [CW-1:0] i_cnt;
  logic [CW-1:0] i_next;
  logic [CW-1:0] j_cnt;
  logic [CW-1:0] j_next;
  logic        out_valid;
  logic        out_valid_next;
  okind_t      okind;
  okind_t      okind_next;
  logic [CMPW-1:0] pc_ext;
  logic [CW-1:0] count;
  logic [CW-1:0] idx;
  logic        adv;
  logic [CW-1:0] i_less_j;
  logic [CW-1:0] i_less_1;

  // Clamp the configured count to 1..MAX_POINTS
  always_comb begin
    pc_ext = CMPW'(point_count);
    if (pc_ext == '0) begin
      count = CW'(1);
    end else if (pc_ext > CMPW'(MAX_POINTS)) begin
      count = CW'(MAX_POINTS);
    end else begin
      count = pc_ext[CW-1:0];
    end
  end

  assign s_tready = (state == S_IDLE);
  assign m_tvalid = out_valid;
  assign idx      = table_ready ? '0 : loaded;
  assign i_less_j = i_cnt - j_cnt;
  assign i_less_1 = i_cnt - CW'(1);

  always_comb begin
    cmd              = '0;
    state_next       = state;
    loaded_next      = loaded;
    table_ready_next = table_ready;
    derr_next        = derr;
    i_next           = i_cnt;
    j_next           = j_cnt;
    okind_next       = okind;
    wr_addr          = '0;
    rd_x_addr        = '0;
    rd_c_addr        = '0;
    adv              = 1'b0;

    unique case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          if (mode == MODE_LOAD) begin
            // Store the point; start a fresh set after a full one
            cmd.wr_x    = 1'b1;
            cmd.wr_c    = 1'b1;
            cmd.wsel    = WSEL_LOAD;
            wr_addr     = idx[AW-1:0];
            if (table_ready) begin
              cmd.clr_bsat     = 1'b1;
              table_ready_next = 1'b0;
              derr_next        = 1'b0;
            end
            loaded_next = idx + CW'(1);
            if (loaded_next >= count) begin
              if (loaded_next > CW'(1)) begin
                j_next     = CW'(1);
                i_next     = loaded_next - CW'(1);
                state_next = S_B_RD1;
              end else begin
                table_ready_next = 1'b1;
              end
            end
          end else begin
            cmd.q_init = 1'b1;
            if (!table_ready) begin
              okind_next = OK_NOT_READY;
              state_next = S_Q_FIN;
            end else if (derr) begin
              okind_next = OK_DIV_ERR;
              state_next = S_Q_FIN;
            end else begin
              okind_next = OK_CALC;
              state_next = S_Q_INIT;
            end
          end
        end
      end
      S_B_RD1: begin
        rd_x_addr  = i_cnt[AW-1:0];
        rd_c_addr  = i_cnt[AW-1:0];
        state_next = S_B_RD2;
      end
      S_B_RD2: begin
        cmd.cap_a  = 1'b1;
        rd_x_addr  = i_less_j[AW-1:0];
        rd_c_addr  = i_less_1[AW-1:0];
        state_next = S_B_CAP;
      end
      S_B_CAP: begin
        cmd.cap_b  = 1'b1;
        state_next = S_B_DIV;
      end
      S_B_DIV: begin
        if (stat.den_zero) begin
          // Repeated x: zero coefficient and flag the set
          cmd.wr_c         = 1'b1;
          cmd.wsel         = WSEL_ZERO;
          cmd.note_num_sat = 1'b1;
          wr_addr          = i_cnt[AW-1:0];
          derr_next        = 1'b1;
          adv              = 1'b1;
        end else begin
          cmd.div_start = 1'b1;
          state_next    = S_B_WAIT;
        end
      end
      S_B_WAIT: begin
        if (stat.div_done) begin
          cmd.wr_c         = 1'b1;
          cmd.wsel         = WSEL_DIV;
          cmd.note_num_sat = 1'b1;
          cmd.note_div_sat = 1'b1;
          wr_addr          = i_cnt[AW-1:0];
          adv              = 1'b1;
        end
      end
      S_Q_INIT: begin
        rd_c_addr  = '0;
        state_next = S_Q_RES;
      end
      S_Q_RES: begin
        cmd.cap_res = 1'b1;
        i_next      = CW'(1);
        state_next  = (loaded > CW'(1)) ? S_Q_RD : S_Q_FIN;
      end
      S_Q_RD: begin
        rd_x_addr  = i_less_1[AW-1:0];
        rd_c_addr  = i_cnt[AW-1:0];
        state_next = S_Q_CAP;
      end
      S_Q_CAP: begin
        cmd.cap_b  = 1'b1;
        state_next = S_Q_MUL1;
      end
      S_Q_MUL1: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = 1'b0;
        state_next    = S_Q_W1;
      end
      S_Q_W1: begin
        if (stat.mul_done) begin
          cmd.upd_prod = 1'b1;
          state_next   = S_Q_MUL2;
        end
      end
      S_Q_MUL2: begin
        cmd.mul_start = 1'b1;
        cmd.mul_sel   = 1'b1;
        state_next    = S_Q_W2;
      end
      S_Q_W2: begin
        cmd.mul_sel = 1'b1;
        if (stat.mul_done) begin
          cmd.acc_term = 1'b1;
          i_next       = i_cnt + CW'(1);
          state_next   = (i_next < loaded) ? S_Q_RD : S_Q_FIN;
        end
      end
      S_Q_FIN: begin
        // Hold until the output register is free
        if (!out_valid || m_tready) begin
          cmd.out_load = 1'b1;
          cmd.okind    = okind;
          state_next   = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase

    // Advance the build: rows downward, then the next column
    if (adv) begin
      if (i_cnt > j_cnt) begin
        i_next     = i_cnt - CW'(1);
        state_next = S_B_RD1;
      end else if (j_cnt + CW'(1) < loaded) begin
        j_next     = j_cnt + CW'(1);
        i_next     = loaded - CW'(1);
        state_next = S_B_RD1;
      end else begin
        table_ready_next = 1'b1;
        state_next       = S_IDLE;
      end
    end

    out_valid_next = out_valid;
    if (cmd.out_load) begin
      out_valid_next = 1'b1;
    end else if (m_tready) begin
      out_valid_next = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      point_count <= 7'd1;
      loaded      <= '0;
      table_ready <= 1'b0;
      derr        <= 1'b0;
      i_cnt       <= '0;
      j_cnt       <= '0;
      out_valid   <= 1'b0;
      okind       <= OK_CALC;
    end else begin
      state       <= state_next;
      loaded      <= loaded_next;
      table_ready <= table_ready_next;
      derr        <= derr_next;
      i_cnt       <= i_next;
      j_cnt       <= j_next;
      out_valid   <= out_valid_next;
      okind       <= okind_next;
      if (cfg_we) begin
        point_count <= cfg_data;
      end
    end
  end

  a_build_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_B_DIV) |-> (i_cnt >= j_cnt) && (j_cnt != '0) && (i_cnt < loaded))
    else $error("build index out of range");

  a_query_index: assert property (@(posedge clk) disable iff (rst)
    (state == S_Q_RD) |-> (i_cnt != '0) && (i_cnt < loaded))
    else $error("query index out of range");

  a_out_free: assert property (@(posedge clk) disable iff (rst)
    cmd.out_load |-> (!out_valid || m_tready))
    else $error("result overwrote a pending transfer");

  a_ready_src: assert property (@(posedge clk) disable iff (rst)
    $rose(table_ready) |-> $past(state == S_IDLE || state == S_B_DIV || state == S_B_WAIT))
    else $error("table marked ready outside a build");

endmodule

// ===== design/newton_interpolator_core.sv =====
// The load that completes a set of n points starts a build of n(n-1)/2 coefficients; each
// one not zeroed for a repeated x is a quotient from the bit-serial divider (80 steps).
// Query: each term takes two passes through the iterative 64x64 multiplier (four 32x32
// partial products). One item is worked on at a time.
// Reset (rst, synchronous) clears the loaded-point count, flags and handshake state and
// sets point_count to 1; the sample and coefficient memories are not cleared.
module newton_interpolator_core #(
  parameter int MAX_POINTS = 64
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [63:0] s_tdata,   // [31:0] x_value, [63:32] y_value
  input  logic        s_tuser,   // [0] mode
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [31:0] y_result
  output logic [1:0]  m_tuser,   // [1:0] status
  input  logic        cfg_we,
  input  logic [6:0]  cfg_data
);
  import nwi_pkg::*;

  localparam int AW = $clog2(MAX_POINTS);
  localparam int CW = $clog2(MAX_POINTS + 1);

  nwi_cmd_t      cmd;
  nwi_stat_t     stat;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] rd_x_addr;
  logic [AW-1:0] rd_c_addr;

  nwi_controller #(
    .MAX_POINTS (MAX_POINTS),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .mode      (s_tuser),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .cfg_we    (cfg_we),
    .cfg_data  (cfg_data),
    .stat      (stat),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_x_addr (rd_x_addr),
    .rd_c_addr (rd_c_addr)
  );

  nwi_datapath #(
    .MAX_POINTS (MAX_POINTS),
    .AW         (AW)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .wr_addr   (wr_addr),
    .rd_x_addr (rd_x_addr),
    .rd_c_addr (rd_c_addr),
    .x_in      (s_tdata[31:0]),
    .y_in      (s_tdata[63:32]),
    .stat      (stat),
    .y_result  (m_tdata),
    .status    (m_tuser)
  );

endmodule
